### src/lcnv_pkg.sv
// Shared constants, types and helpers for the Luhn card number checker.
`default_nettype none

package lcnv_pkg;

    // Card number width and decimal digit budget
    localparam int CARD_W      = 63;
    localparam int BCD_DIGITS  = 19;          // enough for any 63-bit value
    localparam int MAX_DIGITS  = 19;          // lowest digits entering the Luhn sum
    localparam int BCD_W       = 4 * BCD_DIGITS;
    localparam int CNT_W       = $clog2(CARD_W);
    localparam int DIG_IDX_W   = $clog2(BCD_DIGITS);

    localparam logic [CARD_W-1:0] MIN_VALUE = CARD_W'(64'd1000000000000);

    // Job queue geometry
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Verdict codes
    localparam logic [1:0] VERDICT_INVALID = 2'd0;
    localparam logic [1:0] VERDICT_LEAD4   = 2'd1;
    localparam logic [1:0] VERDICT_LEAD3   = 2'd2;
    localparam logic [1:0] VERDICT_LEAD5   = 2'd3;

    typedef logic [3:0] t_digit;

    typedef struct packed {
        logic [CARD_W-1:0] card_number;
        logic              big;          // number above 10^12
    } t_job;

    // Class from the two leading decimal digits
    function automatic logic [1:0] classify(input t_digit first, input t_digit second);
        logic [1:0] v;
        v = VERDICT_INVALID;
        case (first)
            4'd4: begin
                v = VERDICT_LEAD4;
            end
            4'd3: begin
                if (second inside {4'd4, 4'd7}) v = VERDICT_LEAD3;
            end
            4'd5: begin
                if (second inside {[4'd1:4'd5]}) v = VERDICT_LEAD5;
            end
            default: begin
                v = VERDICT_INVALID;
            end
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### src/lcnv_if.sv
// Valid/ready channel interfaces for card numbers and verdicts.
`default_nettype none

interface lcnv_in_if;
    logic                          valid;
    logic                          ready;
    logic [lcnv_pkg::CARD_W-1:0]   card_number;

    modport source (output valid, output card_number, input ready);
    modport sink   (input valid, input card_number, output ready);
endinterface

interface lcnv_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;
    logic       luhn_ok;

    modport source (output valid, output verdict, output luhn_ok, input ready);
    modport sink   (input valid, input verdict, input luhn_ok, output ready);
endinterface

`default_nettype wire

### src/lcnv_front.sv
// Front end: accepts card numbers, flags long ones and hands jobs to the queue.
`default_nettype none

module lcnv_front (
    lcnv_in_if.sink            i_card,
    output logic               o_push_valid,
    output lcnv_pkg::t_job     o_push_job,
    input  logic               i_push_ready
);
    import lcnv_pkg::*;

    assign i_card.ready            = i_push_ready;
    assign o_push_valid            = i_card.valid;
    assign o_push_job.card_number  = i_card.card_number;
    assign o_push_job.big          = (i_card.card_number > MIN_VALUE);

endmodule

`default_nettype wire

### src/lcnv_queue.sv
// Short job queue between front and back end (first-word fall-through).
`default_nettype none

module lcnv_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push_valid,
    input  lcnv_pkg::t_job     i_push_job,
    output logic               o_push_ready,
    output logic               o_pop_valid,
    output lcnv_pkg::t_job     o_pop_job,
    input  logic               i_pop_ready
);
    import lcnv_pkg::*;

    t_job              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr;
    logic [Q_CW-1:0]   r_count;
    logic              w_push;
    logic              w_pop;

    assign o_push_ready = (r_count != Q_CW'(Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (w_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

### src/lcnv_back.sv
// Back end: bit-serial binary to BCD, digit-serial Luhn sum, verdict register.
`default_nettype none

module lcnv_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  lcnv_pkg::t_job     i_job,
    output logic               o_job_ready,
    lcnv_out_if.source         o_result
);
    import lcnv_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_CONV, S_SCAN, S_DONE} t_state;

    t_state              r_state, n_state;
    logic [CARD_W-1:0]   r_bin, n_bin;
    logic [BCD_W-1:0]    r_bcd, n_bcd;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [3:0]          r_sum, n_sum;        // Luhn sum mod 10
    logic                r_big, n_big;
    logic [1:0]          r_lead, n_lead;      // leading digits captured so far
    t_digit              r_d1, n_d1;
    t_digit              r_d2, n_d2;
    logic                r_out_valid, n_out_valid;
    logic [1:0]          r_verdict, n_verdict;
    logic                r_ok, n_ok;

    logic [BCD_W-1:0]    w_adj;
    t_digit              w_digit;
    t_digit              w_dbl;
    t_digit              w_add;
    logic [4:0]          w_sum5;
    logic [4:0]          w_dbl5;
    logic [DIG_IDX_W-1:0] w_idx;
    logic                w_out_free;

    // Double-dabble correction: +3 on every digit of 5 or more
    always_comb begin
        t_digit d;
        for (int k = 0; k < BCD_DIGITS; k++) begin
            d = r_bcd[k*4 +: 4];
            w_adj[k*4 +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
        end
    end

    // Luhn contribution of the digit at the top of the BCD word
    assign w_idx   = r_cnt[DIG_IDX_W-1:0];
    assign w_digit = r_bcd[BCD_W-1 -: 4];
    assign w_dbl5  = {w_digit, 1'b0} - 5'd9;
    assign w_dbl   = (w_digit < 4'd5) ? {w_digit[2:0], 1'b0} : w_dbl5[3:0];

    always_comb begin
        if (w_idx >= DIG_IDX_W'(MAX_DIGITS)) begin
            w_add = 4'd0;
        end else if (w_idx[0]) begin
            w_add = w_dbl;
        end else begin
            w_add = w_digit;
        end
    end

    assign w_sum5     = {1'b0, r_sum} + {1'b0, w_add};
    assign w_out_free = !r_out_valid || o_result.ready;

    assign o_job_ready      = (r_state == S_IDLE);
    assign o_result.valid   = r_out_valid;
    assign o_result.verdict = r_verdict;
    assign o_result.luhn_ok = r_ok;

    always_comb begin
        n_state     = r_state;
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_cnt       = r_cnt;
        n_sum       = r_sum;
        n_big       = r_big;
        n_lead      = r_lead;
        n_d1        = r_d1;
        n_d2        = r_d2;
        n_out_valid = r_out_valid && !o_result.ready;
        n_verdict   = r_verdict;
        n_ok        = r_ok;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_bin   = i_job.card_number;
                    n_big   = i_job.big;
                    n_bcd   = '0;
                    n_cnt   = '0;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_bcd = {w_adj[BCD_W-2:0], r_bin[CARD_W-1]};
                n_bin = {r_bin[CARD_W-2:0], 1'b0};
                if (r_cnt == CNT_W'(CARD_W - 1)) begin
                    n_cnt   = CNT_W'(BCD_DIGITS - 1);
                    n_sum   = 4'd0;
                    n_lead  = 2'd0;
                    n_d1    = 4'd0;
                    n_d2    = 4'd0;
                    n_state = S_SCAN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SCAN: begin
                n_sum = (w_sum5 >= 5'd10) ? 4'(w_sum5 - 5'd10) : w_sum5[3:0];
                if (r_lead == 2'd0 && w_digit != 4'd0) begin
                    n_d1   = w_digit;
                    n_lead = 2'd1;
                end else if (r_lead == 2'd1) begin
                    n_d2   = w_digit;
                    n_lead = 2'd2;
                end
                n_bcd = {r_bcd[BCD_W-5:0], 4'd0};
                if (w_idx == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_ok        = (r_sum == 4'd0);
                    n_verdict   = (r_sum == 4'd0 && r_big) ? classify(r_d1, r_d2)
                                                           : VERDICT_INVALID;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_bin     <= n_bin;
        r_bcd     <= n_bcd;
        r_cnt     <= n_cnt;
        r_sum     <= n_sum;
        r_big     <= n_big;
        r_lead    <= n_lead;
        r_d1      <= n_d1;
        r_d2      <= n_d2;
        r_verdict <= n_verdict;
        r_ok      <= n_ok;
    end

    a_conv_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CONV |-> r_cnt <= CNT_W'(CARD_W - 1))
        else $error("conversion counter overran");

    a_scan_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_cnt <= CNT_W'(BCD_DIGITS - 1))
        else $error("digit index out of range");

    a_job_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_job_valid) |=> r_state == S_CONV)
        else $error("job taken without starting conversion");

    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished job not posted");

    a_class_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_verdict != VERDICT_INVALID) |-> r_ok)
        else $error("class given without Luhn pass");

endmodule

`default_nettype wire

### src/luhn_card_number_validator_core.sv
// Top level of the Luhn mod-10 card number checker.
//
//  port      | dir | carries                      | handshake
//  ----------+-----+------------------------------+------------
//  i_card    | in  | card_number[62:0]            | valid/ready
//  o_result  | out | verdict[1:0], luhn_ok        | valid/ready
//
// Each transaction passes in the back end through a load, the bit-serial
// binary to BCD conversion (one input bit a cycle), the digit-serial Luhn
// sum and leading-digit capture, and the posting of the verdict.
// A two-deep queue lets the front take up to two more numbers meanwhile, and
// the output register holds a verdict while the next number is processed.
// i_rst_n is synchronous, active low; it empties the queue and output slot.
// A stalled o_result holds the back end in its final state only.
`default_nettype none

module luhn_card_number_validator_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    lcnv_in_if.sink     i_card,
    lcnv_out_if.source  o_result
);
    import lcnv_pkg::*;

    // front to queue
    logic   w_push_valid;
    logic   w_push_ready;
    t_job   w_push_job;

    // queue to back end
    logic   w_pop_valid;
    logic   w_pop_ready;
    t_job   w_pop_job;

    // Front: takes a transaction whenever the queue has room and tags it
    // with the "above 10^12" flag, so the back end needs no wide compare.
    lcnv_front u_front (
        .i_card       (i_card),
        .o_push_valid (w_push_valid),
        .o_push_job   (w_push_job),
        .i_push_ready (w_push_ready)
    );

    // Queue: decouples intake from the long serial computation.
    lcnv_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .i_push_job   (w_push_job),
        .o_push_ready (w_push_ready),
        .o_pop_valid  (w_pop_valid),
        .o_pop_job    (w_pop_job),
        .i_pop_ready  (w_pop_ready)
    );

    // Back end: double-dabble, then a scan from the top digit down that
    // keeps the Luhn sum mod 10 and captures the two leading digits.
    lcnv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_pop_valid),
        .i_job       (w_pop_job),
        .o_job_ready (w_pop_ready),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire
